### hw/rtl/dtq_pkg.sv
package dtq_pkg;

    // Default sizing
    localparam int NUM_TIMERS_DEF = 16;
    localparam int TIME_BITS_DEF  = 48;

    // Fixed field widths
    localparam int CMD_BITS   = 3;
    localparam int ID_BITS    = 4;
    localparam int DELAY_BITS = 32;
    localparam int NOW_BITS   = 48;
    localparam int WAIT_BITS  = 48;

    // At most this many timers fire on one tick
    localparam int RESULT_CAP = 16;
    localparam int NF_W       = $clog2(RESULT_CAP + 1);

    localparam logic [WAIT_BITS-1:0] WAIT_MAX = '1;

    // Command codes
    localparam logic [CMD_BITS-1:0] CMD_SETUP   = 3'd0;
    localparam logic [CMD_BITS-1:0] CMD_ACT     = 3'd1;
    localparam logic [CMD_BITS-1:0] CMD_ACT_DLY = 3'd2;
    localparam logic [CMD_BITS-1:0] CMD_CANCEL  = 3'd3;
    localparam logic [CMD_BITS-1:0] CMD_TICK    = 3'd4;

    typedef struct packed {
        logic [CMD_BITS-1:0]   cmd;
        logic [ID_BITS-1:0]    timer_id;
        logic [DELAY_BITS-1:0] delay;
        logic [NOW_BITS-1:0]   now;
    } t_in_word;

    typedef struct packed {
        logic                 fired_valid;
        logic [ID_BITS-1:0]   fired_id;
        logic                 last;
        logic [WAIT_BITS-1:0] next_wait;
    } t_out_word;

    // Scan unit control
    typedef struct packed {
        logic clr;    // start of a pass: drop accumulated results
        logic first;  // first pass of an item: also count due and track future min
    } t_scan_ctl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_ADD,
        S_WR,
        S_SCAN,
        S_WAIT,
        S_EMIT
    } t_state;

endpackage

### hw/rtl/dtq_scan.sv
module dtq_scan #(
    parameter int NUM_TIMERS = dtq_pkg::NUM_TIMERS_DEF,
    parameter int TIME_BITS  = dtq_pkg::TIME_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  dtq_pkg::t_scan_ctl              i_ctl,
    input  logic                            i_elem_vld,
    input  logic [$clog2(NUM_TIMERS)-1:0]   i_elem_idx,
    input  logic                            i_elem_armed,
    input  logic [TIME_BITS-1:0]            i_elem_dl,
    input  logic [TIME_BITS-1:0]            i_now,
    output logic                            o_pick_found,
    output logic [$clog2(NUM_TIMERS)-1:0]   o_pick_id,
    output logic [$clog2(NUM_TIMERS+1)-1:0] o_due_cnt,
    output logic                            o_fut_found,
    output logic [TIME_BITS-1:0]            o_fut_min
);
    import dtq_pkg::*;

    localparam int IW = $clog2(NUM_TIMERS);
    localparam int CW = $clog2(NUM_TIMERS + 1);

    logic                 r_pk_found;
    logic [IW-1:0]        r_pk_id;
    logic [TIME_BITS-1:0] r_pk_dl;
    logic [CW-1:0]        r_due_cnt;
    logic                 r_fut_found;
    logic [TIME_BITS-1:0] r_fut_min;

    logic w_due;
    logic w_pick_upd;
    logic w_fut_upd;

    // Element classification
    assign w_due      = i_elem_vld && i_elem_armed && (i_elem_dl <= i_now);
    assign w_pick_upd = w_due && (!r_pk_found || (i_elem_dl < r_pk_dl));
    assign w_fut_upd  = i_ctl.first && i_elem_vld && i_elem_armed && !w_due &&
                        (!r_fut_found || (i_elem_dl < r_fut_min));

    // Earliest due timer; strict compare keeps the lower id on ties
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr) begin
            r_pk_found <= 1'b0;
        end else if (w_pick_upd) begin
            r_pk_found <= 1'b1;
        end
        if (w_pick_upd) begin
            r_pk_id <= i_elem_idx;
            r_pk_dl <= i_elem_dl;
        end
    end

    // Due count and earliest future deadline, first pass only
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr) begin
            r_due_cnt   <= '0;
            r_fut_found <= 1'b0;
        end else begin
            if (i_ctl.first && w_due) begin
                r_due_cnt <= r_due_cnt + CW'(1);
            end
            if (w_fut_upd) begin
                r_fut_found <= 1'b1;
            end
        end
        if (w_fut_upd) begin
            r_fut_min <= i_elem_dl;
        end
    end

    assign o_pick_found = r_pk_found;
    assign o_pick_id    = r_pk_id;
    assign o_due_cnt    = r_due_cnt;
    assign o_fut_found  = r_fut_found;
    assign o_fut_min    = r_fut_min;

endmodule

### hw/rtl/deadline_timer_queue.sv
// Non-tick command: states read, add, write, scan, wait, emit; one result word per accepted
// word, and the next word is taken only after that result word is loaded.
// Tick firing k timers (k up to 16): k scans and k result words, each scan after the first
// following the previous word; a tick that fires nothing gives one word.
// One item in flight; the per-slot deadline scan sets the rate, output stalls add to it.
// Reset clears armed flags and default-delay valid bits; deadline memory stays undefined.
module deadline_timer_queue #(
    parameter int NUM_TIMERS = dtq_pkg::NUM_TIMERS_DEF,
    parameter int TIME_BITS  = dtq_pkg::TIME_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  dtq_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output dtq_pkg::t_out_word o_out_word
);
    import dtq_pkg::*;

    localparam int IW = $clog2(NUM_TIMERS);
    localparam int CW = $clog2(NUM_TIMERS + 1);
    localparam int NW = (TIME_BITS < NOW_BITS) ? TIME_BITS : NOW_BITS;
    localparam int SW = ((TIME_BITS > DELAY_BITS) ? TIME_BITS : DELAY_BITS) + 1;
    localparam int WW = (TIME_BITS > WAIT_BITS) ? TIME_BITS : WAIT_BITS;
    localparam logic [TIME_BITS-1:0] TMAX = '1;

    t_state r_state, n_state;

    // Captured command
    logic [CMD_BITS-1:0]   r_cmd;
    logic [ID_BITS-1:0]    r_id;
    logic                  r_id_ok;
    logic [DELAY_BITS-1:0] r_delay;
    logic [TIME_BITS-1:0]  r_now;

    // Memories and flags
    logic [TIME_BITS-1:0]  r_dl_mem  [NUM_TIMERS];
    logic [DELAY_BITS-1:0] r_dly_mem [NUM_TIMERS];
    logic [TIME_BITS-1:0]  r_dl_rd;
    logic [DELAY_BITS-1:0] r_dly_rd;
    logic [NUM_TIMERS-1:0] r_armed;
    logic [NUM_TIMERS-1:0] r_dly_set;

    logic [TIME_BITS-1:0]  r_new_dl;

    // Scan sequencing
    logic [CW-1:0] r_cnt;
    logic          r_pv;
    logic [IW-1:0] r_pidx;
    logic          r_first;

    // Result sequencing
    logic [NF_W-1:0]      r_nfire;
    logic [NF_W-1:0]      r_fired;
    logic [WAIT_BITS-1:0] r_wait;
    logic                 r_out_vld;
    t_out_word            r_out;

    // Control
    logic          w_take;
    logic [IW-1:0] w_idx;
    logic [IW-1:0] w_rd_addr;
    logic          w_dl_re;
    logic          w_dly_re;
    logic          w_dl_we;
    logic          w_dly_we;
    logic          w_arm_set;
    logic          w_arm_clr;
    logic          w_scan_issue;
    logic          w_scan_done;
    logic          w_scan_start;
    t_scan_ctl     w_scan_ctl;
    logic          w_emit_ld;
    logic          w_fire;
    logic          w_last;
    logic [NF_W-1:0] w_fired_inc;
    logic          w_armed_cur;
    logic          w_push_later;
    logic [DELAY_BITS-1:0] w_dflt;
    logic [DELAY_BITS-1:0] w_add_src;
    logic [SW-1:0] w_sum;

    // Scan results
    logic                 w_pick_found;
    logic [IW-1:0]        w_pick_id;
    logic [CW-1:0]        w_due_cnt;
    logic                 w_fut_found;
    logic [TIME_BITS-1:0] w_fut_min;
    logic [TIME_BITS-1:0] w_diff;
    logic [WW-1:0]        w_diff_w;
    logic                 w_rem_due;

    assign w_take       = i_in_valid && o_in_ready;
    assign w_idx        = IW'(r_id);
    assign w_armed_cur  = r_armed[w_idx];
    assign w_scan_issue = (r_state == S_SCAN) && (r_cnt != CW'(NUM_TIMERS));
    assign w_scan_done  = (r_cnt == CW'(NUM_TIMERS)) && r_pv;
    assign w_fire       = (r_fired != r_nfire);
    assign w_fired_inc  = r_fired + NF_W'(1);
    assign w_last       = !w_fire || (w_fired_inc == r_nfire);
    assign w_emit_ld    = (r_state == S_EMIT) && (!r_out_vld || i_out_ready);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_take) begin
                    n_state = (i_in_word.cmd == CMD_TICK) ? S_SCAN : S_RD;
                end
            end
            S_RD:   n_state = S_ADD;
            S_ADD:  n_state = S_WR;
            S_WR:   n_state = S_SCAN;
            S_SCAN: begin
                if (w_scan_done) begin
                    n_state = r_first ? S_WAIT : S_EMIT;
                end
            end
            S_WAIT: n_state = S_EMIT;
            S_EMIT: begin
                if (w_emit_ld) begin
                    n_state = w_last ? S_IDLE : S_SCAN;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        w_dl_re   = 1'b0;
        w_dly_re  = 1'b0;
        w_rd_addr = w_idx;
        w_dl_we   = 1'b0;
        w_dly_we  = 1'b0;
        w_arm_set = 1'b0;
        w_arm_clr = 1'b0;
        unique case (r_state)
            S_RD: begin
                w_dl_re  = 1'b1;
                w_dly_re = 1'b1;
            end
            S_WR: begin
                if (r_id_ok) begin
                    unique case (r_cmd) inside
                        CMD_SETUP: w_dly_we = 1'b1;
                        CMD_ACT, CMD_ACT_DLY: begin
                            if (!w_armed_cur) begin
                                w_dl_we   = 1'b1;
                                w_arm_set = 1'b1;
                            end else if (w_push_later) begin
                                w_dl_we = 1'b1;
                            end
                        end
                        CMD_CANCEL: w_arm_clr = 1'b1;
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                w_dl_re   = w_scan_issue;
                w_rd_addr = r_cnt[IW-1:0];
            end
            default: ;
        endcase
    end

    assign w_push_later = (r_cmd == CMD_ACT_DLY) && (r_new_dl > r_dl_rd);
    assign w_scan_start = (n_state == S_SCAN) && (r_state != S_SCAN);
    assign w_scan_ctl   = '{clr: w_scan_start, first: r_first};

    // State and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_pv      <= 1'b0;
            r_first   <= 1'b0;
            r_fired   <= '0;
            r_nfire   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_scan_start) begin
                r_cnt <= '0;
                r_pv  <= 1'b0;
            end else begin
                if (w_scan_issue) begin
                    r_cnt <= r_cnt + CW'(1);
                end
                r_pv <= w_scan_issue;
            end
            if (w_take) begin
                r_first <= 1'b1;
                r_fired <= '0;
            end else if (r_state == S_WAIT) begin
                r_first <= 1'b0;
            end
            if (r_state == S_WAIT) begin
                if (r_cmd != CMD_TICK) begin
                    r_nfire <= '0;
                end else if (32'(w_due_cnt) > RESULT_CAP) begin
                    r_nfire <= NF_W'(RESULT_CAP);
                end else begin
                    r_nfire <= NF_W'(w_due_cnt);
                end
            end
            if (w_emit_ld && w_fire) begin
                r_fired <= w_fired_inc;
            end
            if (w_emit_ld) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Command capture
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_cmd   <= i_in_word.cmd;
            r_id    <= i_in_word.timer_id;
            r_id_ok <= (32'(i_in_word.timer_id) < NUM_TIMERS);
            r_delay <= i_in_word.delay;
            r_now   <= TIME_BITS'(i_in_word.now[NW-1:0]);
        end
        if (w_scan_issue) begin
            r_pidx <= r_cnt[IW-1:0];
        end
    end

    // Deadline memory
    always_ff @(posedge i_clk) begin
        if (w_dl_we) begin
            r_dl_mem[w_idx] <= r_new_dl;
        end
        if (w_dl_re) begin
            r_dl_rd <= r_dl_mem[w_rd_addr];
        end
    end

    // Default delay memory
    always_ff @(posedge i_clk) begin
        if (w_dly_we) begin
            r_dly_mem[w_idx] <= r_delay;
        end
        if (w_dly_re) begin
            r_dly_rd <= r_dly_mem[w_idx];
        end
    end

    // Armed flags and default-delay valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed   <= '0;
            r_dly_set <= '0;
        end else begin
            if (w_arm_set) begin
                r_armed[w_idx] <= 1'b1;
            end
            if (w_arm_clr) begin
                r_armed[w_idx] <= 1'b0;
            end
            if (w_emit_ld && w_fire) begin
                r_armed[w_pick_id] <= 1'b0;
            end
            if (w_dly_we) begin
                r_dly_set[w_idx] <= 1'b1;
            end
        end
    end

    // Saturating deadline: an armed push uses the command delay, else the default
    assign w_dflt    = r_dly_set[w_idx] ? r_dly_rd : '0;
    assign w_add_src = (w_armed_cur && (r_cmd == CMD_ACT_DLY)) ? r_delay : w_dflt;
    assign w_sum     = SW'(r_now) + SW'(w_add_src);

    always_ff @(posedge i_clk) begin
        if (r_state == S_ADD) begin
            r_new_dl <= (w_sum > SW'(TMAX)) ? TMAX : TIME_BITS'(w_sum);
        end
    end

    dtq_scan #(
        .NUM_TIMERS (NUM_TIMERS),
        .TIME_BITS  (TIME_BITS)
    ) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_scan_ctl),
        .i_elem_vld   (r_pv),
        .i_elem_idx   (r_pidx),
        .i_elem_armed (r_armed[r_pidx]),
        .i_elem_dl    (r_dl_rd),
        .i_now        (r_now),
        .o_pick_found (w_pick_found),
        .o_pick_id    (w_pick_id),
        .o_due_cnt    (w_due_cnt),
        .o_fut_found  (w_fut_found),
        .o_fut_min    (w_fut_min)
    );

    // Wait to the earliest deadline left after the command
    assign w_diff    = w_fut_min - r_now;
    assign w_diff_w  = WW'(w_diff);
    assign w_rem_due = (r_cmd == CMD_TICK) ? (32'(w_due_cnt) > RESULT_CAP)
                                           : (w_due_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (r_state == S_WAIT) begin
            if (w_rem_due || !w_fut_found) begin
                r_wait <= '0;
            end else if (w_diff_w > WW'(WAIT_MAX)) begin
                r_wait <= WAIT_MAX;
            end else begin
                r_wait <= w_diff_w[WAIT_BITS-1:0];
            end
        end
    end

    // Output word register
    always_ff @(posedge i_clk) begin
        if (w_emit_ld) begin
            r_out.fired_valid <= w_fire && w_pick_found;
            r_out.fired_id    <= w_fire ? ID_BITS'(w_pick_id) : '0;
            r_out.last        <= w_last;
            r_out.next_wait   <= r_wait;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

endmodule
